FILE: design/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared word types and controller/datapath interface types for the
// stream reassembler.
// ----------------------------------------------------------------------------
package trs_pkg;

  // Command codes carried by an input word
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Fixed field widths
  localparam int unsigned IndexW = 32;
  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic              command;
    logic [IndexW-1:0] index;
    logic [7:0]        byte_value;
    logic              has_byte;
    logic              segment_last;
    logic              segment_eof;
    logic [CountW-1:0] read_count;
  } trs_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              stream_ended;
    logic [CountW-1:0] pending_count;
    logic              pending_none;
    logic [CountW-1:0] unread_total;
  } trs_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic drain;
    logic stat;
  } trs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_start;
    logic scan_done;
    logic drain_done;
    logic out_free;
  } trs_status_t;

endpackage

FILE: design/trs_ctrl.sv
// ----------------------------------------------------------------------------
// trs_ctrl
// Sequencer: accept a word, scan the in-order run, drain it, or emit a
// single status word.
// ----------------------------------------------------------------------------
module trs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  trs_pkg::trs_status_t status_i,
  output trs_pkg::trs_cmd_t    cmd_o
);
  import trs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_STAT  = 4'b1000
  } trs_state_e;

  trs_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Drive datapath commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.drain  = (state_q == ST_DRAIN);
    cmd_o.stat   = (state_q == ST_STAT);
  end

  // Advance state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.run_start ? ST_SCAN : ST_STAT;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.drain_done) state_d = ST_IDLE;
      end
      ST_STAT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/trs_datapath.sv
// ----------------------------------------------------------------------------
// trs_datapath
// Window store, held map, stream counters, run scan and drain pipeline,
// and the output register.
// ----------------------------------------------------------------------------
module trs_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trs_pkg::trs_in_t     in_data_i,
  input  trs_pkg::trs_cmd_t    cmd_i,
  output trs_pkg::trs_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output trs_pkg::trs_out_t    out_data_o
);
  import trs_pkg::*;

  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [SW:0]   CapS = (SW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);
  localparam logic [SW-1:0] LastSlot = SW'(CAPACITY - 1);

  // Window store, no reset
  logic [7:0] mem_q [CAPACITY];
  logic [7:0] rdata_q;

  logic [CAPACITY-1:0] held_q, held_d;
  logic [32:0]   ne_q, ne_d;
  logic [SW-1:0] ne_slot_q, ne_slot_d;
  logic [CW-1:0] unread_q, unread_d;
  logic [CW-1:0] pending_q, pending_d;
  logic          eof_known_q, eof_known_d;
  logic [32:0]   eof_pos_q, eof_pos_d;
  logic          ended_q, ended_d;
  logic          seg_ovf_q, seg_ovf_d;

  logic [SW-1:0] scan_p_q, scan_p_d;
  logic [CW-1:0] scan_c_q, scan_c_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          rdv_q, rdv_d;
  logic          rlast_q, rlast_d;

  logic          out_valid_q, out_valid_d;
  trs_out_t      out_q, out_d;

  // Push decode
  logic [32:0]   idx_ext, limit, seg_end, diff;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot, slot_inc;
  logic          is_push, in_window, store, store_new, run_start;
  logic          seg_ovf_cur, fits;
  logic [CountW-1:0] unread_w, rd_sat;

  // Scan, drain and output handshake
  logic          out_free, scan_done, scan_end, issue, move;
  logic [32:0]   ne_final;
  logic          ended_next;

  assign idx_ext   = {1'b0, in_data_i.index};
  assign limit     = ne_q - 33'(unread_q) + 33'(CAPACITY);
  assign seg_end   = idx_ext + 33'(in_data_i.has_byte);
  assign diff      = idx_ext - ne_q;
  assign slot_sum  = {1'b0, ne_slot_q} + {1'b0, diff[SW-1:0]};
  assign slot      = (slot_sum >= CapS) ? SW'(slot_sum - CapS) : slot_sum[SW-1:0];
  assign slot_inc  = (slot == LastSlot) ? '0 : slot + 1'b1;

  assign is_push   = cmd_i.accept && (in_data_i.command == CMD_PUSH);
  assign in_window = idx_ext < limit;
  assign store     = in_data_i.has_byte && in_window && !ended_q && (idx_ext >= ne_q);
  assign store_new = is_push && store && !held_q[slot];
  assign run_start = (in_data_i.command == CMD_PUSH) && store && (idx_ext == ne_q);

  assign seg_ovf_cur = seg_ovf_q || (in_data_i.has_byte && !in_window);
  assign fits        = !seg_ovf_cur && (seg_end <= limit);

  assign unread_w = CountW'(unread_q);
  assign rd_sat   = (in_data_i.read_count > unread_w) ? unread_w : in_data_i.read_count;

  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_done = !held_q[scan_p_q] || (scan_c_q == CapC);
  assign scan_end  = cmd_i.scan && scan_done;
  assign move      = cmd_i.drain && rdv_q && out_free;
  assign issue     = cmd_i.drain && (rem_q != '0) && (!rdv_q || move);

  assign ne_final   = scan_end ? ne_q + 33'(scan_c_q) : ne_q;
  assign ended_next = ended_q || (eof_known_q && (ne_final >= eof_pos_q));

  always_comb begin
    status_o            = '0;
    status_o.run_start  = run_start;
    status_o.scan_done  = scan_done;
    status_o.drain_done = move && rlast_q;
    status_o.out_free   = out_free;
  end

  // Update stream state
  always_comb begin
    held_d      = held_q;
    ne_d        = ne_q;
    ne_slot_d   = ne_slot_q;
    unread_d    = unread_q;
    pending_d   = pending_q;
    eof_known_d = eof_known_q;
    eof_pos_d   = eof_pos_q;
    ended_d     = ended_q;
    seg_ovf_d   = seg_ovf_q;
    scan_p_d    = scan_p_q;
    scan_c_d    = scan_c_q;
    rem_d       = rem_q;
    rdv_d       = rdv_q;
    rlast_d     = rlast_q;

    // Apply a read: free window space
    if (cmd_i.accept && (in_data_i.command == CMD_READ)) begin
      unread_d = unread_q - CW'(rd_sat);
    end

    // Apply a push: store byte, track segment fit and eof
    if (is_push) begin
      if (store_new) begin
        held_d[slot] = 1'b1;
        pending_d    = pending_q + 1'b1;
      end
      if (in_data_i.segment_last) begin
        if (in_data_i.segment_eof && fits && !eof_known_q) begin
          eof_known_d = 1'b1;
          eof_pos_d   = seg_end;
        end
        seg_ovf_d = 1'b0;
      end else begin
        seg_ovf_d = seg_ovf_cur;
      end
      if (run_start) begin
        scan_p_d = slot_inc;
        scan_c_d = CW'(1);
      end
    end

    // Walk the contiguous run; at its end commit the final counters
    if (cmd_i.scan) begin
      if (scan_done) begin
        rem_d     = scan_c_q;
        ne_d      = ne_final;
        pending_d = pending_q - scan_c_q;
        unread_d  = unread_q + scan_c_q;
        ended_d   = ended_next;
      end else begin
        scan_c_d = scan_c_q + 1'b1;
        scan_p_d = (scan_p_q == LastSlot) ? '0 : scan_p_q + 1'b1;
      end
    end

    // Status-only word: settle the ended flag
    if (cmd_i.stat && out_free) begin
      ended_d = ended_next;
    end

    // Drain: read slot, release it, advance
    if (move) begin
      rdv_d = 1'b0;
    end
    if (issue) begin
      held_d[ne_slot_q] = 1'b0;
      ne_slot_d         = (ne_slot_q == LastSlot) ? '0 : ne_slot_q + 1'b1;
      rem_d             = rem_q - 1'b1;
      rdv_d             = 1'b1;
      rlast_d           = (rem_q == CW'(1));
    end
  end

  // Load the output register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (cmd_i.stat && out_free) begin
      out_valid_d         = 1'b1;
      out_d.out_byte      = '0;
      out_d.byte_valid    = 1'b0;
      out_d.run_last      = 1'b1;
      out_d.stream_ended  = ended_next;
      out_d.pending_count = CountW'(pending_q);
      out_d.pending_none  = (pending_q == '0);
      out_d.unread_total  = CountW'(unread_q);
    end else if (move) begin
      out_valid_d         = 1'b1;
      out_d.out_byte      = rdata_q;
      out_d.byte_valid    = 1'b1;
      out_d.run_last      = rlast_q;
      out_d.stream_ended  = ended_q;
      out_d.pending_count = CountW'(pending_q);
      out_d.pending_none  = (pending_q == '0);
      out_d.unread_total  = CountW'(unread_q);
    end
  end

  // Window store write and registered read
  always_ff @(posedge clk_i) begin
    if (store_new) begin
      mem_q[slot] <= in_data_i.byte_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rdata_q <= mem_q[ne_slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      ne_q        <= '0;
      ne_slot_q   <= '0;
      unread_q    <= '0;
      pending_q   <= '0;
      eof_known_q <= 1'b0;
      eof_pos_q   <= '0;
      ended_q     <= 1'b0;
      seg_ovf_q   <= 1'b0;
      scan_p_q    <= '0;
      scan_c_q    <= '0;
      rem_q       <= '0;
      rdv_q       <= 1'b0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      ne_q        <= ne_d;
      ne_slot_q   <= ne_slot_d;
      unread_q    <= unread_d;
      pending_q   <= pending_d;
      eof_known_q <= eof_known_d;
      eof_pos_q   <= eof_pos_d;
      ended_q     <= ended_d;
      seg_ovf_q   <= seg_ovf_d;
      scan_p_q    <= scan_p_d;
      scan_c_q    <= scan_c_d;
      rem_q       <= rem_d;
      rdv_q       <= rdv_d;
      rlast_q     <= rlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload needs no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/tcp_stream_reassembler.sv
// ----------------------------------------------------------------------------
// tcp_stream_reassembler
// A word with no in-order byte gives one status word, loaded into the output
// register from the status state. A word that completes a run of bytes scans the
// held map, then drains one byte per cycle through the registered read port while
// the output is not stalled. Output stalls hold both the drain and the status
// word; the next word is taken once the last result is registered.
// Reset clears the held map and counters at once; the byte store has no reset.
// ----------------------------------------------------------------------------
module tcp_stream_reassembler #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  trs_pkg::trs_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output trs_pkg::trs_out_t out_data_o
);
  import trs_pkg::*;

  trs_cmd_t    cmd;
  trs_status_t status;

  // Sequencer
  trs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store, counters and output register
  trs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/tcp_stream_reassembler_test.sv
// ----------------------------------------------------------------------------
// tcp_stream_reassembler_test
// Self-checking bench for the stream reassembler. A scripted head walks the
// window edges, duplicates, stale and dropped bytes, refused eof marks and
// saturating reads. Random segments with random content, reads and stray
// words follow, then a scripted tail closes the stream. Every accepted input
// word is run through a local copy of the reassembly rules, and every output
// word is checked field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tcp_stream_reassembler_test;
  import trs_pkg::*;

  localparam int CAP = 64;
  localparam int RAND_ITEMS = 190;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    bit       rel;     // index is an offset from the next in-order position
    trs_in_t  word;
    bit       typed;   // result typed in below instead of predicted
    trs_out_t result;
  } script_row_t;

  logic     clk_i = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  trs_in_t  in_word = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  trs_out_t out_word;

  // Predicted stream state
  logic [7:0]  win_bytes [CAP];
  bit          held [CAP];
  logic [32:0] next_pos;
  logic [6:0]  unread_n;
  logic [6:0]  pending_n;
  bit          eof_seen;
  logic [32:0] eof_at;
  bit          ended;
  bit          seg_dropped;

  trs_out_t    expected_words [$];
  script_row_t script_rows [$];
  int          err_count = 0;
  int          burst_left = 0;
  bit          long_hold_due = 1'b0;

  tcp_stream_reassembler #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Print one line per mismatch and count it
  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error(what, got, want);
    end
  endtask

  function automatic trs_in_t push_word(logic [31:0] idx, logic [7:0] val, logic has,
                                        logic last, logic eof);
    trs_in_t w;
    w = '0;
    w.command      = CMD_PUSH;
    w.index        = idx;
    w.byte_value   = val;
    w.has_byte     = has;
    w.segment_last = last;
    w.segment_eof  = eof;
    return w;
  endfunction

  function automatic trs_in_t read_word(logic [6:0] cnt);
    trs_in_t w;
    w = '0;
    w.command    = CMD_READ;
    w.read_count = cnt;
    return w;
  endfunction

  // Status-only word of a stream that has not ended
  function automatic trs_out_t status_word(logic [6:0] pend, logic [6:0] unread);
    trs_out_t r;
    r = '0;
    r.run_last      = 1'b1;
    r.pending_count = pend;
    r.pending_none  = (pend == 0);
    r.unread_total  = unread;
    return r;
  endfunction

  function automatic void add_row(bit rel, trs_in_t w, bit typed, trs_out_t res);
    script_row_t row;
    row.rel    = rel;
    row.word   = w;
    row.typed  = typed;
    row.result = res;
    script_rows.push_back(row);
  endfunction

  function automatic logic [63:0] window_limit();
    logic [63:0] pos;
    pos = next_pos;
    return pos - unread_n + CAP;
  endfunction

  // Apply one accepted word to the predicted state and queue its results
  task automatic model_word(input trs_in_t w);
    logic [7:0]  run_bytes [CAP];
    logic [63:0] limit, seg_end, idx;
    logic [6:0]  cnt;
    trs_out_t    r;
    int          n;
    int          slot;
    n = 0;
    if (w.command == CMD_READ) begin
      cnt = w.read_count;
      if (cnt > unread_n) begin
        cnt = unread_n;
      end
      unread_n = unread_n - cnt;
    end else begin
      idx     = w.index;
      limit   = window_limit();
      seg_end = w.has_byte ? idx + 1 : idx;
      if (w.has_byte) begin
        if (idx >= limit) begin
          seg_dropped = 1'b1;
        end else if (!ended && idx >= next_pos) begin
          slot = int'(idx % CAP);
          if (!held[slot]) begin
            held[slot]      = 1'b1;
            win_bytes[slot] = w.byte_value;
            pending_n++;
          end
          // Drain the contiguous run starting at the next position
          while (n < CAP && held[int'(next_pos % CAP)]) begin
            slot = int'(next_pos % CAP);
            run_bytes[n] = win_bytes[slot];
            n++;
            held[slot] = 1'b0;
            pending_n--;
            unread_n++;
            next_pos++;
          end
        end
      end
      if (w.segment_last) begin
        if (w.segment_eof && !seg_dropped && seg_end <= limit && !eof_seen) begin
          eof_seen = 1'b1;
          eof_at   = seg_end[32:0];
        end
        seg_dropped = 1'b0;
      end
      if (eof_seen && next_pos >= eof_at) begin
        ended = 1'b1;
      end
    end
    r = '0;
    r.stream_ended  = ended;
    r.pending_count = pending_n;
    r.pending_none  = (pending_n == 0);
    r.unread_total  = unread_n;
    if (n == 0) begin
      r.run_last = 1'b1;
      expected_words.push_back(r);
    end
    for (int k = 0; k < n; k++) begin
      r.out_byte   = run_bytes[k];
      r.byte_valid = 1'b1;
      r.run_last   = (k == n - 1);
      expected_words.push_back(r);
    end
  endtask

  // Offer one word, opening a new burst after a random gap when due
  task automatic send_word(input trs_in_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic deliver(input trs_in_t w);
    send_word(w);
    model_word(w);
  endtask

  task automatic issue_row(input int i);
    trs_in_t w;
    int      depth;
    w = script_rows[i].word;
    if (script_rows[i].rel) begin
      w.index = next_pos[31:0] + script_rows[i].word.index;
    end
    send_word(w);
    depth = expected_words.size();
    model_word(w);
    // Replace the prediction with the typed-in result
    if (script_rows[i].typed) begin
      while (expected_words.size() > depth) begin
        expected_words.delete(expected_words.size() - 1);
      end
      expected_words.push_back(script_rows[i].result);
    end
  endtask

  // One well-formed segment near the next position, in or out of order
  task automatic run_segment(output int sent);
    trs_in_t     w;
    logic [31:0] start;
    int          len, lead, back;
    bit          reverse;
    lead  = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 40);
    back  = (next_pos >= 3 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    start = next_pos[31:0] + lead - back;
    if ($urandom_range(0, 9) == 0) begin
      w = push_word(start + $urandom_range(0, 5), $urandom_range(0, 255), 1'b0, 1'b1, 1'b0);
      w.read_count = $urandom_range(0, 64);
      deliver(w);
      sent = 1;
    end else begin
      len     = $urandom_range(1, 8);
      reverse = $urandom_range(0, 1);
      for (int k = 0; k < len; k++) begin
        w = push_word(reverse ? start + len - 1 - k : start + k, $urandom_range(0, 255),
                      1'b1, k == len - 1, 1'b0);
        // The eof bit only counts on the closing word
        if (k != len - 1) begin
          w.segment_eof = $urandom_range(0, 1);
        end
        w.read_count = $urandom_range(0, 64);
        deliver(w);
      end
      sent = len;
    end
  endtask

  // Stray word at a random index, with an eof mark only where it is refused
  task automatic run_noise();
    trs_in_t     w;
    logic [63:0] idx;
    w = push_word($urandom, $urandom_range(0, 255), $urandom_range(0, 1),
                  $urandom_range(0, 1), 1'b0);
    w.read_count = $urandom_range(0, 64);
    idx = w.index;
    if (w.has_byte ? idx >= window_limit() : idx > window_limit()) begin
      w.segment_eof = $urandom_range(0, 1);
    end
    deliver(w);
  endtask

  // Check each output word against the oldest prediction
  always @(posedge clk_i) begin : check_results
    trs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        flag_error("unexpected word", out_word.out_byte, 0);
      end else begin
        want = expected_words.pop_front();
        check_field("out_byte", out_word.out_byte, want.out_byte);
        check_field("byte_valid", out_word.byte_valid, want.byte_valid);
        check_field("run_last", out_word.run_last, want.run_last);
        check_field("stream_ended", out_word.stream_ended, want.stream_ended);
        check_field("pending_count", out_word.pending_count, want.pending_count);
        check_field("pending_none", out_word.pending_none, want.pending_none);
        check_field("unread_total", out_word.unread_total, want.unread_total);
      end
    end
  end

  // Receiver: random stall modes, plus one long hold-off
  initial begin : drive_ready
    int  mode, mode_left, hold_left;
    bit  hold_done;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_due && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= $urandom_range(0, 1);
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int head_rows, items_done, sent, pick;
    for (int i = 0; i < CAP; i++) begin
      held[i]      = 1'b0;
      win_bytes[i] = '0;
    end
    next_pos    = '0;
    unread_n    = '0;
    pending_n   = '0;
    eof_seen    = 1'b0;
    eof_at      = '0;
    ended       = 1'b0;
    seg_dropped = 1'b0;

    // Head: window edges, duplicates, stale bytes, refused eof, saturating reads
    add_row(0, read_word(0), 1, status_word(0, 0));
    add_row(0, read_word(64), 1, status_word(0, 0));
    add_row(0, push_word(1, 8'hFF, 1, 1, 0), 1, status_word(1, 0));
    add_row(0, push_word(1, 8'h00, 1, 1, 0), 1, status_word(1, 0));
    add_row(0, push_word(0, 8'h00, 1, 1, 0), 0, '0);
    add_row(0, push_word(0, 8'hAA, 1, 1, 0), 1, status_word(0, 2));
    add_row(0, push_word(66, 8'h5A, 1, 1, 1), 1, status_word(0, 2));
    add_row(0, push_word(32'hFFFF_FFFF, 8'hFF, 1, 1, 1), 1, status_word(0, 2));
    add_row(0, read_word(1), 1, status_word(0, 1));
    add_row(0, push_word(64, 8'h3C, 1, 1, 0), 1, status_word(1, 1));
    add_row(0, push_word(65, 8'hC3, 1, 1, 0), 1, status_word(1, 1));
    add_row(0, push_word(0, 8'h00, 0, 1, 0), 1, status_word(1, 1));
    add_row(0, push_word(3, 8'h33, 1, 0, 0), 1, status_word(2, 1));
    add_row(0, push_word(2, 8'h22, 1, 1, 0), 0, '0);
    add_row(0, read_word(64), 1, status_word(1, 0));
    add_row(0, push_word(70, 8'h70, 1, 0, 0), 1, status_word(1, 0));
    add_row(0, push_word(5, 8'h55, 1, 1, 1), 1, status_word(2, 0));
    add_row(0, push_word(4, 8'h44, 1, 1, 0), 0, '0);
    add_row(0, push_word(32'h8000_0000, 8'h00, 0, 0, 0), 1, status_word(1, 2));
    head_rows = script_rows.size();

    // Tail: accept an eof, ignore a second one, reach it, then ignore bytes
    add_row(0, read_word(64), 0, '0);
    add_row(1, push_word(0, 8'h00, 0, 1, 0), 0, '0);
    add_row(1, push_word(1, 8'hA5, 1, 0, 0), 0, '0);
    add_row(1, push_word(0, 8'h5A, 1, 0, 0), 0, '0);
    add_row(0, read_word(64), 0, '0);
    add_row(1, push_word(2, 8'h00, 0, 1, 1), 0, '0);
    add_row(1, push_word(1, 8'h00, 0, 1, 1), 0, '0);
    add_row(1, push_word(1, 8'hB1, 1, 0, 0), 0, '0);
    add_row(1, push_word(0, 8'hB0, 1, 1, 0), 0, '0);
    add_row(1, push_word(0, 8'hEE, 1, 1, 1), 0, '0);
    add_row(0, read_word(64), 0, '0);

    // Hold reset, then release it
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < head_rows; i++) begin
      issue_row(i);
    end

    // Random part: mostly segments, some reads, a few stray words
    items_done = 0;
    while (items_done < RAND_ITEMS) begin
      if (items_done >= 60) begin
        long_hold_due = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        deliver(read_word(($urandom_range(0, 4) == 0) ? 64 : $urandom_range(0, 64)));
        items_done++;
      end else if (pick < 90) begin
        run_segment(sent);
        items_done += sent;
      end else begin
        run_noise();
      end
    end

    for (int i = head_rows; i < script_rows.size(); i++) begin
      issue_row(i);
    end
    in_valid <= 1'b0;

    // Wait out the remaining results, then watch for strays
    while (expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/trs_pkg.sv
design/trs_ctrl.sv
design/trs_datapath.sv
design/tcp_stream_reassembler.sv
tb/sv/tcp_stream_reassembler_test.sv
